FILE: rtl/gmdfs_pkg.sv
// Shared types, constants and helpers for the grid maze depth-first search block.
`default_nettype none
package gmdfs_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int BOUND_W    = 5;
    localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int DEPTH_W    = CELL_W + 1;

    typedef logic [1:0] cell_code_t;
    localparam cell_code_t CODE_PATH  = 2'd0;
    localparam cell_code_t CODE_WALL  = 2'd1;
    localparam cell_code_t CODE_EXIT  = 2'd2;
    localparam cell_code_t CODE_TRIED = 2'd3;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_USED = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_USED = 1'b1;

    typedef logic [2:0] dir_t;
    localparam dir_t DIR_RIGHT = 3'd0;
    localparam dir_t DIR_DOWN  = 3'd1;
    localparam dir_t DIR_LEFT  = 3'd2;
    localparam dir_t DIR_UP    = 3'd3;
    localparam dir_t DIR_DONE  = 3'd4;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        dir_t             dir;
    } frame_t;

    typedef struct packed {
        logic             valid;
        logic             op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        cell_code_t       code;
    } cmd_t;

    typedef struct packed {
        logic [BOUND_W-1:0] rows_lim;
        logic [BOUND_W-1:0] cols_lim;
    } bounds_t;

    typedef struct packed {
        logic valid;
        logic found;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_POP,
        ST_DONE
    } search_state_t;

    function automatic logic [CELL_W-1:0] cell_index(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        int idx;
        idx = int'(r) * MAX_COLS + int'(c);
        return idx[CELL_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gmdfs_engine.sv
// Search engine: grid memory, walk stack and the sequencer that drives one probe at a time.
`default_nettype none
module gmdfs_engine
    import gmdfs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    input  wire bounds_t bounds,
    input  wire logic    out_free,
    output logic         ready,
    output result_t      result
);

    logic [1:0]        grid_mem [GRID_CELLS];
    frame_t            stk_mem  [GRID_CELLS];

    search_state_t     state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    frame_t            top_reg, top_next;
    logic [ROW_W-1:0]  cand_row_reg, cand_row_next;
    logic [COL_W-1:0]  cand_col_reg, cand_col_next;
    logic              found_reg, found_next;
    cell_code_t        grid_rd_reg;
    frame_t            stk_rd_reg;

    logic              grid_we, grid_re;
    logic [CELL_W-1:0] grid_waddr, grid_raddr;
    cell_code_t        grid_wdata;
    logic              stk_we, stk_re;
    logic [CELL_W-1:0] stk_waddr, stk_raddr;

    logic [BOUND_W-1:0] nb_row, nb_col;
    logic              nb_in, start_in, load_in, top_done;

    always_comb
    begin
        nb_row = {1'b0, top_reg.row};
        nb_col = {1'b0, top_reg.col};
        case (top_reg.dir)
            DIR_RIGHT: nb_col = {1'b0, top_reg.col} + BOUND_W'(1);
            DIR_DOWN:  nb_row = {1'b0, top_reg.row} + BOUND_W'(1);
            DIR_LEFT:  nb_col = {1'b0, top_reg.col} - BOUND_W'(1);
            DIR_UP:    nb_row = {1'b0, top_reg.row} - BOUND_W'(1);
            default:   nb_row = {1'b0, top_reg.row};
        endcase
    end

    // An underflow wraps to all ones, which is never inside the bounds.
    assign nb_in    = (nb_row < bounds.rows_lim) && (nb_col < bounds.cols_lim);
    assign start_in = ({1'b0, cmd.row} < bounds.rows_lim) && ({1'b0, cmd.col} < bounds.cols_lim);
    assign load_in  = ({1'b0, cmd.row} < BOUND_W'(MAX_ROWS))
                   && ({1'b0, cmd.col} < BOUND_W'(MAX_COLS));
    assign top_done = (top_reg.dir == DIR_DONE);
    assign ready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && cmd.op == OP_SEARCH)
                begin
                    state_next = start_in ? ST_CHECK : ST_DONE;
                end
            end
            ST_CHECK:
            begin
                if (grid_rd_reg == CODE_EXIT)
                begin
                    state_next = ST_DONE;
                end
                else if (grid_rd_reg == CODE_PATH || depth_reg != '0)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STEP:
            begin
                if (top_done)
                begin
                    state_next = (depth_reg == DEPTH_W'(1)) ? ST_DONE : ST_POP;
                end
                else if (nb_in)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_POP:  state_next = ST_STEP;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        grid_we       = 1'b0;
        grid_waddr    = cell_index(cand_row_reg, cand_col_reg);
        grid_wdata    = CODE_TRIED;
        grid_re       = 1'b0;
        grid_raddr    = cell_index(cmd.row, cmd.col);
        stk_we        = 1'b0;
        stk_waddr     = CELL_W'(depth_reg - DEPTH_W'(1));
        stk_re        = 1'b0;
        stk_raddr     = CELL_W'(depth_reg - DEPTH_W'(2));
        cand_row_next = cand_row_reg;
        cand_col_next = cand_col_reg;
        top_next      = top_reg;
        depth_next    = depth_reg;
        found_next    = found_reg;
        result.valid  = 1'b0;
        result.found  = found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && cmd.op == OP_LOAD)
                begin
                    grid_we    = load_in;
                    grid_waddr = cell_index(cmd.row, cmd.col);
                    grid_wdata = cmd.code;
                end
                else if (cmd.valid)
                begin
                    cand_row_next = cmd.row;
                    cand_col_next = cmd.col;
                    depth_next    = '0;
                    found_next    = 1'b0;
                    grid_re       = start_in;
                end
            end
            ST_CHECK:
            begin
                if (grid_rd_reg == CODE_EXIT)
                begin
                    found_next = 1'b1;
                end
                else if (grid_rd_reg == CODE_PATH)
                begin
                    grid_we    = 1'b1;
                    stk_we     = (depth_reg != '0);
                    top_next   = '{row: cand_row_reg, col: cand_col_reg, dir: DIR_RIGHT};
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end
            ST_STEP:
            begin
                if (top_done)
                begin
                    depth_next = depth_reg - DEPTH_W'(1);
                    stk_re     = 1'b1;
                end
                else
                begin
                    top_next.dir  = top_reg.dir + dir_t'(1);
                    cand_row_next = nb_row[ROW_W-1:0];
                    cand_col_next = nb_col[COL_W-1:0];
                    grid_re       = nb_in;
                    grid_raddr    = cell_index(nb_row[ROW_W-1:0], nb_col[COL_W-1:0]);
                end
            end
            ST_POP:  top_next = stk_rd_reg;
            ST_DONE: result.valid = out_free;
            default: result.valid = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_re)
        begin
            grid_rd_reg <= grid_mem[grid_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= top_reg;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        cand_row_reg <= cand_row_next;
        cand_col_reg <= cand_col_next;
        top_reg      <= top_next;
        found_reg    <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            depth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(GRID_CELLS))
        else $error("walk stack depth exceeds the grid size");

    a_step_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP || state_reg == ST_POP) |-> depth_reg != '0)
        else $error("walk step taken with an empty stack");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> $past(grid_re))
        else $error("cell checked without a preceding grid read");

    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> ($past(stk_re) && $past(state_reg) == ST_STEP))
        else $error("stack pop without a preceding stack read");

endmodule
`default_nettype wire

FILE: rtl/grid_maze_depth_first_search.sv
// Top level of the grid maze depth-first search block: ports, bound registers, result register.
`default_nettype none
// A load item writes one two-bit cell of the 16 x 16 grid. A search item walks the
// maze depth first from its start cell and returns one item with the found flag. Each
// neighbor probe that lies inside the bounds is a grid read, then a check; a probe
// outside the bounds reads no cell, and each backtrack is a stack read, then a reload
// of the top frame. The grid memory has a single read port. Cells tried during a
// search stay marked until they are loaded again. The bound registers may be
// written only while no item is in progress.
module grid_maze_depth_first_search
    import gmdfs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BOUND_W-1:0]     cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   op,
    input  wire logic [ROW_W-1:0]       row,
    input  wire logic [COL_W-1:0]       col,
    input  wire logic [1:0]             cell_code,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        found
);

    logic [BOUND_W-1:0] rows_used_reg, rows_used_next;
    logic [BOUND_W-1:0] cols_used_reg, cols_used_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic               engine_ready;
    logic               out_free;
    cmd_t               cmd;
    bounds_t            bounds;
    result_t            result;

    always_comb
    begin
        rows_used_next = rows_used_reg;
        cols_used_next = cols_used_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_USED: rows_used_next = cfg_data;
                CFG_COLS_USED: cols_used_next = cfg_data;
                default:       rows_used_next = rows_used_reg;
            endcase
        end
    end

    assign bounds.rows_lim = (rows_used_reg > BOUND_W'(MAX_ROWS)) ? BOUND_W'(MAX_ROWS)
                                                                  : rows_used_reg;
    assign bounds.cols_lim = (cols_used_reg > BOUND_W'(MAX_COLS)) ? BOUND_W'(MAX_COLS)
                                                                  : cols_used_reg;

    assign in_stall  = !engine_ready;
    assign cmd.valid = in_valid && engine_ready;
    assign cmd.op    = op;
    assign cmd.row   = row;
    assign cmd.col   = col;
    assign cmd.code  = cell_code;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
            out_found_next = result.found;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    gmdfs_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .bounds   (bounds),
        .out_free (out_free),
        .ready    (engine_ready),
        .result   (result)
    );

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= BOUND_W'(16);
            cols_used_reg <= BOUND_W'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_used_reg <= rows_used_next;
            cols_used_reg <= cols_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;

endmodule
`default_nettype wire

FILE: tb/grid_maze_depth_first_search_tb.sv
// Testbench for the grid maze depth-first search block: stimulus, cell-grid predictor and checker.
module grid_maze_depth_first_search_tb;
    import gmdfs_pkg::*;

    localparam int TOTAL_ITEMS  = 580;
    localparam int MIN_SEARCHES = 60;
    localparam int QUIET_ITEMS  = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT    = 100_000_000;

    typedef enum int {PROBE_FAIL, PROBE_EXIT, PROBE_PUSHED} probe_t;

    typedef struct packed {
        bit                 set_bounds;
        logic [BOUND_W-1:0] rows_val;
        logic [BOUND_W-1:0] cols_val;
        logic               item_op;
        logic [ROW_W-1:0]   item_row;
        logic [COL_W-1:0]   item_col;
        cell_code_t         item_code;
        bit                 typed;
        bit                 typed_found;
    } plan_step_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROWS_USED;
    logic [BOUND_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = OP_LOAD;
    logic [ROW_W-1:0]   row = '0;
    logic [COL_W-1:0]   col = '0;
    logic [1:0]         cell_code = CODE_PATH;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               found;

    cell_code_t         maze_cells [GRID_CELLS];
    int                 trail_cell [GRID_CELLS];
    dir_t               trail_dir [GRID_CELLS];
    int                 trail_depth = 0;
    logic [BOUND_W-1:0] rows_cfg = 5'd16;
    logic [BOUND_W-1:0] cols_cfg = 5'd16;

    logic               expected_found [$];
    plan_step_t         plan [$];
    logic               found_want;
    int                 fail_count = 0;
    int                 items_sent = 0;
    int                 searches_done = 0;
    int                 stall_left = 0;
    bit                 idle_on = 1'b1;
    bit                 quiet = 1'b0;

    grid_maze_depth_first_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row       (row),
        .col       (col),
        .cell_code (cell_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found)
    );

    always #10 clk = ~clk;

    function automatic probe_t probe_cell(input int r, input int c, input int rows, input int cols);
        int idx;
        if (r < 0 || r >= rows || c < 0 || c >= cols)
            return PROBE_FAIL;
        idx = r * MAX_COLS + c;
        if (maze_cells[idx] == CODE_EXIT)
            return PROBE_EXIT;
        if (maze_cells[idx] == CODE_WALL || maze_cells[idx] == CODE_TRIED)
            return PROBE_FAIL;
        maze_cells[idx] = CODE_TRIED;
        trail_cell[trail_depth] = idx;
        trail_dir[trail_depth] = DIR_RIGHT;
        trail_depth = trail_depth + 1;
        return PROBE_PUSHED;
    endfunction

    function automatic logic search_exit(input int r0, input int c0);
        int   rows;
        int   cols;
        int   top;
        int   r;
        int   c;
        dir_t d;
        logic hit;
        rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        cols = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
        trail_depth = 0;
        hit = (probe_cell(r0, c0, rows, cols) == PROBE_EXIT);
        while (!hit && trail_depth > 0)
        begin
            top = trail_depth - 1;
            r = trail_cell[top] / MAX_COLS;
            c = trail_cell[top] % MAX_COLS;
            d = trail_dir[top];
            if (d >= DIR_DONE)
            begin
                trail_depth = trail_depth - 1;
            end
            else
            begin
                trail_dir[top] = dir_t'(d + 1);
                case (d)
                    DIR_RIGHT: c = c + 1;
                    DIR_DOWN:  r = r + 1;
                    DIR_LEFT:  c = c - 1;
                    default:   r = r - 1;
                endcase
                if (probe_cell(r, c, rows, cols) == PROBE_EXIT)
                    hit = 1'b1;
            end
        end
        trail_depth = 0;
        return hit;
    endfunction

    function automatic plan_step_t plan_step(input bit set_bounds, input int rows_val,
                                             input int cols_val, input logic item_op,
                                             input int item_row, input int item_col,
                                             input cell_code_t item_code, input bit typed,
                                             input bit typed_found);
        plan_step_t s;
        s.set_bounds  = set_bounds;
        s.rows_val    = rows_val[BOUND_W-1:0];
        s.cols_val    = cols_val[BOUND_W-1:0];
        s.item_op     = item_op;
        s.item_row    = item_row[ROW_W-1:0];
        s.item_col    = item_col[COL_W-1:0];
        s.item_code   = item_code;
        s.typed       = typed;
        s.typed_found = typed_found;
        return s;
    endfunction

    function automatic cell_code_t pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return CODE_PATH;
        if (roll < 80)
            return CODE_WALL;
        if (roll < 90)
            return CODE_EXIT;
        return CODE_TRIED;
    endfunction

    task automatic send_item(input logic item_op, input int item_row, input int item_col,
                             input cell_code_t item_code, input bit typed,
                             input bit typed_found);
        int   gap;
        logic hit;
        if (idle_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        op        <= item_op;
        row       <= item_row[ROW_W-1:0];
        col       <= item_col[COL_W-1:0];
        cell_code <= item_code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (item_op == OP_SEARCH)
        begin
            hit = search_exit(item_row[ROW_W-1:0], item_col[COL_W-1:0]);
            expected_found.push_back(typed ? typed_found : hit);
            searches_done++;
        end
        else
        begin
            maze_cells[int'(item_row[ROW_W-1:0]) * MAX_COLS + int'(item_col[COL_W-1:0])] =
                item_code;
        end
        items_sent++;
    endtask

    task automatic reprogram_bounds(input int rows_val, input int cols_val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_found.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS_USED;
        cfg_data  <= rows_val[BOUND_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_COLS_USED;
        cfg_data  <= cols_val[BOUND_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        rows_cfg = rows_val[BOUND_W-1:0];
        cols_cfg = cols_val[BOUND_W-1:0];
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_found.size() == 0)
            begin
                $error("found: expected none, actual %0d", found);
                fail_count++;
            end
            else
            begin
                found_want = expected_found.pop_front();
                if (found !== found_want)
                begin
                    $error("found: expected %0d, actual %0d", found_want, found);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int r;
        int c;
        int sr;
        int sc;
        int er;
        int ec;
        int rows_pick;
        int cols_pick;
        int sel;
        int steps;
        int n;

        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 0, 0, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 0, 1, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 0, 2, CODE_EXIT, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 0, 0, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 0, 2, CODE_PATH, 1, 1));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 0, 0, CODE_PATH, 1, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 5, 5, CODE_WALL, 1, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 3, 3, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 3, 2, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 2, 2, CODE_EXIT, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 3, 3, CODE_TRIED, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 15, 15, CODE_EXIT, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 15, 14, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_LOAD, 15, 13, CODE_TRIED, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 15, 14, CODE_EXIT, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 15, 13, CODE_PATH, 1, 0));
        plan.push_back(plan_step(1, 0, 16, OP_SEARCH, 15, 15, CODE_PATH, 1, 0));
        plan.push_back(plan_step(1, 31, 31, OP_SEARCH, 15, 15, CODE_PATH, 1, 1));
        plan.push_back(plan_step(1, 16, 0, OP_SEARCH, 0, 2, CODE_PATH, 1, 0));
        plan.push_back(plan_step(1, 1, 1, OP_LOAD, 0, 0, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 0, 0, CODE_PATH, 0, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 1, 0, CODE_PATH, 1, 0));
        plan.push_back(plan_step(0, 0, 0, OP_SEARCH, 0, 15, CODE_PATH, 1, 0));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Every cell is written once so that no search ever reads an unloaded cell.
        for (r = 0; r < MAX_ROWS; r++)
            for (c = 0; c < MAX_COLS; c++)
                send_item(OP_LOAD, r, c, CODE_WALL, 0, 0);

        foreach (plan[i])
        begin
            if (plan[i].set_bounds)
                reprogram_bounds(plan[i].rows_val, plan[i].cols_val);
            send_item(plan[i].item_op, plan[i].item_row, plan[i].item_col,
                      plan[i].item_code, plan[i].typed, plan[i].typed_found);
        end

        while (items_sent < TOTAL_ITEMS || searches_done < MIN_SEARCHES)
        begin
            sel = $urandom_range(0, 15);
            case (sel)
                0:
                begin
                    rows_pick = $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
                    cols_pick = (rows_pick == 0) ? $urandom_range(1, 16) : 0;
                end
                1:
                begin
                    rows_pick = $urandom_range(17, 31);
                    cols_pick = $urandom_range(17, 31);
                end
                2:
                begin
                    rows_pick = 16;
                    cols_pick = 16;
                end
                3:
                begin
                    rows_pick = 1;
                    cols_pick = 1;
                end
                default:
                begin
                    rows_pick = $urandom_range(1, 6);
                    cols_pick = $urandom_range(1, 6);
                end
            endcase
            reprogram_bounds(rows_pick, cols_pick);
            quiet = (items_sent >= TOTAL_ITEMS - QUIET_ITEMS);
            idle_on = ($urandom_range(0, 3) != 0);
            er = (rows_pick > MAX_ROWS) ? MAX_ROWS : rows_pick;
            ec = (cols_pick > MAX_COLS) ? MAX_COLS : cols_pick;

            if (er * ec > 36)
            begin
                r = $urandom_range(0, er - 1);
                c = $urandom_range(0, ec - 1);
                sr = r;
                sc = c;
                steps = $urandom_range(10, 40);
                repeat (steps)
                begin
                    send_item(OP_LOAD, r, c, CODE_PATH, 0, 0);
                    case ($urandom_range(0, 3))
                        0: if (c < ec - 1) c++;
                        1: if (r < er - 1) r++;
                        2: if (c > 0) c--;
                        default: if (r > 0) r--;
                    endcase
                end
                if (r != sr || c != sc)
                    send_item(OP_LOAD, r, c, CODE_EXIT, 0, 0);
                send_item(OP_SEARCH, sr, sc, pick_code(), 0, 0);
            end
            else
            begin
                for (r = 0; r < er; r++)
                    for (c = 0; c < ec; c++)
                        send_item(OP_LOAD, r, c, pick_code(), 0, 0);
            end

            n = $urandom_range(0, 2);
            repeat (n)
                send_item(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 15), pick_code(),
                          0, 0);

            n = $urandom_range(2, 4);
            repeat (n)
            begin
                if (er * ec > 0 && $urandom_range(0, 99) < 85)
                begin
                    r = $urandom_range(0, er - 1);
                    c = $urandom_range(0, ec - 1);
                end
                else
                begin
                    r = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                end
                send_item(OP_SEARCH, r, c, pick_code(), 0, 0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_found.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
